// File: sv/nda_pkg.sv
package nda_pkg;

  localparam int NUM_DIGITS = 6;
  localparam int DIGIT_W    = 4;
  localparam int IDX_W      = 3;
  localparam int INTERVAL_W = 16;

  localparam logic [DIGIT_W-1:0] BLANK_CODE   = 4'hF;
  localparam logic [DIGIT_W-1:0] DARK_CODE    = 4'd10;
  localparam logic [DIGIT_W-1:0] TOP_DIGIT    = 4'd9;
  localparam logic [IDX_W-1:0]   LAST_STEP    = 3'd6;

  localparam logic [INTERVAL_W-1:0] ANIM_INTERVAL_RST = 16'd100;
  localparam logic [INTERVAL_W-1:0] SEC_INTERVAL_RST  = 16'd50;
  localparam logic [INTERVAL_W-1:0] MH_INTERVAL_RST   = 16'd50;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_STATIC  = 2'd1,
    MODE_FLY_IN  = 2'd2,
    MODE_FLY_OUT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_FLY_IN  = 2'd1,
    FUNC_FLY_OUT = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    REG_ANIM_INTERVAL = 3'd0,
    REG_SEC_INTERVAL  = 3'd1,
    REG_MH_INTERVAL   = 3'd2,
    REG_ROLL_SEC_UNIT = 3'd3,
    REG_ROLL_BLANK    = 3'd4
  } reg_idx_t;

  // sequencer state besides the digits
  typedef struct packed {
    mode_t            mode;
    logic [IDX_W-1:0] step;
    logic             hv;
    logic             force_pend;
  } ctrl_t;

  // interval events for the current tick
  typedef struct packed {
    logic anim;
    logic sec_roll;
    logic mh_roll;
  } fire_t;

endpackage

// File: sv/nda_step.sv
module nda_step
  import nda_pkg::*;
(
  input  ctrl_t   ctrl,
  input  digits_t digits,
  input  func_t   func,
  input  digits_t target,
  input  logic    force_roll,
  input  fire_t   fire,
  input  logic    roll_sec_unit,
  input  logic    roll_blank,
  output ctrl_t   ctrl_next,
  output digits_t digits_next
);

  function automatic logic [DIGIT_W-1:0] roll_down(input logic [DIGIT_W-1:0] d,
                                                   input logic blank);
    if (d == '0) begin
      return blank ? DARK_CODE : TOP_DIGIT;
    end
    return d - 1'b1;
  endfunction

  logic                force_now;
  logic [DIGIT_W-1:0]  v;
  logic [DIGIT_W:0]    k;

  always_comb begin
    force_now   = ctrl.force_pend | force_roll;
    ctrl_next   = ctrl;
    ctrl_next.force_pend = force_now;
    digits_next = digits;
    v = '0;
    k = '0;

    case (func)
      FUNC_TICK: begin
        if (fire.sec_roll) begin
          if (target[5] != digits[5]) begin
            digits_next[5] = roll_sec_unit ? roll_down(digits[5], roll_blank) : target[5];
          end
          if (target[4] != digits[4]) begin
            digits_next[4] = roll_down(digits[4], roll_blank);
          end
        end
        if (fire.mh_roll) begin
          for (int i = 0; i < 4; i++) begin
            v = force_now ? roll_down(digits[i], roll_blank) : digits[i];
            if (target[i] != v) begin
              digits_next[i] = roll_down(v, roll_blank);
            end
          end
          ctrl_next.force_pend = 1'b0;
        end
        if (fire.anim) begin
          if (ctrl.mode == MODE_FLY_IN) begin
            if (ctrl.step == '0) begin
              digits_next  = {NUM_DIGITS{BLANK_CODE}};
              ctrl_next.hv = 1'b1;
              ctrl_next.step = IDX_W'(1);
            end else if (ctrl.step <= LAST_STEP) begin
              // positions left of the step count take the rightmost targets
              for (int i = 0; i < NUM_DIGITS; i++) begin
                if (IDX_W'(i) < ctrl.step) begin
                  k = (DIGIT_W+1)'(NUM_DIGITS + i) - {2'b00, ctrl.step};
                  digits_next[i] = target[k[IDX_W-1:0]];
                end
              end
              if (ctrl.step == LAST_STEP) begin
                ctrl_next.mode = MODE_STATIC;
                ctrl_next.step = '0;
              end else begin
                ctrl_next.step = ctrl.step + 1'b1;
              end
            end
          end else if (ctrl.mode == MODE_FLY_OUT) begin
            if (ctrl.step == '0) begin
              digits_next    = target;
              ctrl_next.step = IDX_W'(1);
            end else if (ctrl.step <= LAST_STEP) begin
              for (int i = 0; i < NUM_DIGITS; i++) begin
                if (IDX_W'(i) >= ctrl.step) begin
                  k = (DIGIT_W+1)'(i) - {2'b00, ctrl.step};
                  digits_next[i] = target[k[IDX_W-1:0]];
                end else if (IDX_W'(i) == ctrl.step - 1'b1) begin
                  digits_next[i] = BLANK_CODE;
                end
              end
              if (ctrl.step == LAST_STEP) begin
                ctrl_next.mode = MODE_OFF;
                ctrl_next.step = '0;
                ctrl_next.hv   = 1'b0;
              end else begin
                ctrl_next.step = ctrl.step + 1'b1;
              end
            end
          end
        end
      end
      FUNC_FLY_IN: begin
        ctrl_next.mode = MODE_FLY_IN;
        ctrl_next.step = '0;
      end
      FUNC_FLY_OUT: begin
        ctrl_next.mode = MODE_FLY_OUT;
        ctrl_next.step = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/nixie_digit_animator.sv
// six-digit nixie sequencer: rolls digits toward their targets and runs
// fly-in / fly-out animations, paced by millisecond tick beats
//
// input channel s_axis: one beat per tick or command; tuser carries the
// function (tick, start fly-in, start fly-out), tdata the six target digits
// and the force-roll request
// output channel m_axis: exactly one beat per input beat, giving the digit
// drive codes, supply enable and animation mode after that input
// config port: cfg_we/cfg_index/cfg_data write one register per clock; the user
// must write only while the channels are idle, the block does not enforce it
//
// latency: the result beat is valid the cycle after the input beat is taken
// throughput: one beat per cycle; the state registers double as the output
// register, so the next input is taken in the same cycle the result leaves
// stall: while m_axis_tready is low a waiting result holds and s_axis_tready
// drops; nothing is lost or repeated
// reset: tube blank (code 15), supply off, mode off, timers cleared,
// registers at their default intervals
module nixie_digit_animator
  import nda_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target_digit_0..5 [23:0], force_roll [24], zero [31:25]
  input  logic [31:0] s_axis_tdata,
  // func [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // shown_digit_0..5 [23:0], hv_enable [24], anim_mode [26:25], zero [31:27]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // compare width wide enough for both the timers and the interval registers
  localparam int CMP_W = (TIMER_BITS > INTERVAL_W) ? TIMER_BITS : INTERVAL_W;

  // configuration registers
  logic [INTERVAL_W-1:0] anim_interval;
  logic [INTERVAL_W-1:0] sec_interval;
  logic [INTERVAL_W-1:0] mh_interval;
  logic                  roll_sec_unit;
  logic                  roll_blank;

  // sequencer state
  ctrl_t   ctrl, ctrl_next;
  digits_t digits, digits_next;
  logic [TIMER_BITS-1:0] since_anim, since_sec, since_mh;
  logic [TIMER_BITS-1:0] since_anim_next, since_sec_next, since_mh_next;
  logic [TIMER_BITS-1:0] anim_bump, sec_bump, mh_bump;

  logic    accept;
  logic    tick;
  logic    is_static;
  func_t   func;
  digits_t target;
  fire_t   fire;

  // state only moves when the previous result has left or is leaving
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign func   = func_t'(s_axis_tuser);
  assign target = s_axis_tdata[NUM_DIGITS*DIGIT_W-1:0];
  assign tick   = (func == FUNC_TICK);
  assign is_static = (ctrl.mode == MODE_STATIC);

  // saturating millisecond timers
  assign anim_bump = (since_anim == '1) ? since_anim : since_anim + 1'b1;
  assign sec_bump  = (since_sec == '1)  ? since_sec  : since_sec + 1'b1;
  assign mh_bump   = (since_mh == '1)   ? since_mh   : since_mh + 1'b1;

  // interval events: rolls only in the static mode, animation steps otherwise
  always_comb begin
    fire.sec_roll = tick && is_static &&
                    (CMP_W'(sec_bump) >= CMP_W'(sec_interval));
    fire.mh_roll  = tick && is_static &&
                    (CMP_W'(mh_bump) >= CMP_W'(mh_interval));
    fire.anim     = tick && !is_static &&
                    (CMP_W'(anim_bump) >= CMP_W'(anim_interval));
  end

  always_comb begin
    since_anim_next = since_anim;
    since_sec_next  = since_sec;
    since_mh_next   = since_mh;
    if (tick) begin
      since_anim_next = fire.anim     ? '0 : anim_bump;
      since_sec_next  = fire.sec_roll ? '0 : sec_bump;
      since_mh_next   = fire.mh_roll  ? '0 : mh_bump;
    end
  end

  nda_step u_step (
    .ctrl          (ctrl),
    .digits        (digits),
    .func          (func),
    .target        (target),
    .force_roll    (s_axis_tdata[NUM_DIGITS*DIGIT_W]),
    .fire          (fire),
    .roll_sec_unit (roll_sec_unit),
    .roll_blank    (roll_blank),
    .ctrl_next     (ctrl_next),
    .digits_next   (digits_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      anim_interval <= ANIM_INTERVAL_RST;
      sec_interval  <= SEC_INTERVAL_RST;
      mh_interval   <= MH_INTERVAL_RST;
      roll_sec_unit <= 1'b1;
      roll_blank    <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ANIM_INTERVAL: anim_interval <= cfg_data;
        REG_SEC_INTERVAL:  sec_interval  <= cfg_data;
        REG_MH_INTERVAL:   mh_interval   <= cfg_data;
        REG_ROLL_SEC_UNIT: roll_sec_unit <= cfg_data[0];
        REG_ROLL_BLANK:    roll_blank    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.mode       <= MODE_OFF;
      ctrl.step       <= '0;
      ctrl.hv         <= 1'b0;
      ctrl.force_pend <= 1'b0;
      digits          <= {NUM_DIGITS{BLANK_CODE}};
      since_anim      <= '0;
      since_sec       <= '0;
      since_mh        <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        ctrl       <= ctrl_next;
        digits     <= digits_next;
        since_anim <= since_anim_next;
        since_sec  <= since_sec_next;
        since_mh   <= since_mh_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // the result beat is the state after the accepted input
  assign m_axis_tdata = {5'b0, ctrl.mode, ctrl.hv, digits};

endmodule

// File: tb/tb_nixie_digit_animator.sv
`timescale 1ns / 100ps

module tb_nixie_digit_animator;
  import nda_pkg::*;

  localparam int TIMER_W     = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SHOW_MAX    = 10;
  localparam int IDLE_PCT    = 37;

  // func code 3 has no meaning in the block: it only latches force_roll
  localparam logic [1:0] FUNC_UNDEF = 2'd3;

  // expected output beat, packed the same way as m_axis_tdata[26:0]
  typedef struct packed {
    mode_t   mode;
    logic    hv;
    digits_t digits;
  } display_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // target_digit_0..5 [23:0], force_roll [24], zero [31:25]
  logic [31:0] s_axis_tdata  = '0;
  // func [1:0]
  logic [1:0]  s_axis_tuser  = FUNC_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // shown_digit_0..5 [23:0], hv_enable [24], anim_mode [26:25], zero [31:27]
  logic [31:0] m_axis_tdata;
  logic        cfg_we        = 1'b0;
  logic [2:0]  cfg_index     = REG_ANIM_INTERVAL;
  logic [15:0] cfg_data      = '0;

  nixie_digit_animator #(
    .TIMER_BITS(TIMER_W)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // shadow copy of the sequencer: configuration and state
  // ---------------------------------------------------------------------
  logic [15:0]        c_anim = ANIM_INTERVAL_RST;
  logic [15:0]        c_sec  = SEC_INTERVAL_RST;
  logic [15:0]        c_mh   = MH_INTERVAL_RST;
  logic               c_rsu  = 1'b1;
  logic               c_rtb  = 1'b0;

  digits_t            p_digits = {NUM_DIGITS{BLANK_CODE}};
  mode_t              p_mode   = MODE_OFF;
  logic [IDX_W-1:0]   p_step   = '0;
  logic               p_hv     = 1'b0;
  logic               p_force  = 1'b0;
  logic [TIMER_W-1:0] p_since_anim = '0;
  logic [TIMER_W-1:0] p_since_sec  = '0;
  logic [TIMER_W-1:0] p_since_mh   = '0;

  display_t expected_displays[$];

  int  mismatches      = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  settings_used   = 0;
  int  cycle_count     = 0;
  int  hold_left       = 0;
  bit  gaps_on         = 1'b1;

  function automatic logic [DIGIT_W-1:0] roll_digit_down(input logic [DIGIT_W-1:0] d);
    if (d == '0) return c_rtb ? DARK_CODE : TOP_DIGIT;
    return d - 1'b1;
  endfunction

  function automatic logic [TIMER_W-1:0] saturating_inc(input logic [TIMER_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // one accepted beat: update the shadow state, queue the display it leaves
  task automatic advance_display(input logic [1:0] fn, input digits_t tg, input logic fr);
    int i;
    int s;
    logic [DIGIT_W-1:0] v;
    if (fr) p_force = 1'b1;
    s = int'(p_step);
    if (fn == FUNC_TICK) begin
      p_since_anim = saturating_inc(p_since_anim);
      p_since_sec  = saturating_inc(p_since_sec);
      p_since_mh   = saturating_inc(p_since_mh);
      if (p_mode == MODE_STATIC) begin
        if (p_since_sec >= c_sec) begin
          if (tg[5] != p_digits[5]) p_digits[5] = c_rsu ? roll_digit_down(p_digits[5]) : tg[5];
          if (tg[4] != p_digits[4]) p_digits[4] = roll_digit_down(p_digits[4]);
          p_since_sec = '0;
        end
        if (p_since_mh >= c_mh) begin
          // a pending force rolls one extra step before the compare
          for (i = 3; i >= 0; i--) begin
            v = p_digits[i];
            if (p_force) v = roll_digit_down(v);
            if (tg[i] != v) p_digits[i] = roll_digit_down(v);
          end
          p_force    = 1'b0;
          p_since_mh = '0;
        end
      end else if (p_since_anim >= c_anim) begin
        if (p_mode == MODE_FLY_IN) begin
          if (s == 0) begin
            p_digits = {NUM_DIGITS{BLANK_CODE}};
            p_hv     = 1'b1;
            p_step   = 3'd1;
          end else if (s <= int'(LAST_STEP)) begin
            // targets come in from the right
            for (i = 0; i < s; i++) p_digits[i] = tg[NUM_DIGITS - s + i];
            if (s == int'(LAST_STEP)) begin
              p_mode = MODE_STATIC;
              p_step = '0;
            end else begin
              p_step = p_step + 1'b1;
            end
          end
        end else if (p_mode == MODE_FLY_OUT) begin
          if (s == 0) begin
            p_digits = tg;
            p_step   = 3'd1;
          end else if (s <= int'(LAST_STEP)) begin
            // blank from the left while the targets slide right
            p_digits[s-1] = BLANK_CODE;
            for (i = s; i < NUM_DIGITS; i++) p_digits[i] = tg[i - s];
            if (s == int'(LAST_STEP)) begin
              p_step = '0;
              p_hv   = 1'b0;
              p_mode = MODE_OFF;
            end else begin
              p_step = p_step + 1'b1;
            end
          end
        end
        p_since_anim = '0;
      end
    end else if (fn == FUNC_FLY_IN) begin
      p_mode = MODE_FLY_IN;
      p_step = '0;
    end else if (fn == FUNC_FLY_OUT) begin
      p_mode = MODE_FLY_OUT;
      p_step = '0;
    end
    expected_displays.push_back('{mode: p_mode, hv: p_hv, digits: p_digits});
  endtask

  // ---------------------------------------------------------------------
  // input side: drive at the falling edge, beat taken at the rising edge;
  // returns right at the accepting edge so a following beat can go
  // out back to back without touching tvalid twice in one step
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [1:0] fn, input digits_t tg, input logic fr);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {7'b0, fr, tg};
    do @(posedge clk); while (!s_axis_tready);
    advance_display(fn, tg, fr);
    items_sent++;
  endtask

  // stop offering and let every queued result come out
  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_displays.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic set_config(input logic [15:0] anim, input logic [15:0] sec,
                            input logic [15:0] mh, input logic rsu, input logic rtb);
    wait_for_results();
    write_reg(REG_ANIM_INTERVAL, anim);
    write_reg(REG_SEC_INTERVAL, sec);
    write_reg(REG_MH_INTERVAL, mh);
    write_reg(REG_ROLL_SEC_UNIT, {15'b0, rsu});
    write_reg(REG_ROLL_BLANK, {15'b0, rtb});
    @(negedge clk);
    cfg_we <= 1'b0;
    c_anim = anim;
    c_sec  = sec;
    c_mh   = mh;
    c_rsu  = rsu;
    c_rtb  = rtb;
    settings_used++;
  endtask

  // a plausible hh:mm:ss target, now and then with a blanked digit
  function automatic digits_t rand_clock_time();
    digits_t d;
    d[0] = 4'($urandom_range(0, 2));
    d[1] = 4'($urandom_range(0, 9));
    d[2] = 4'($urandom_range(0, 5));
    d[3] = 4'($urandom_range(0, 9));
    d[4] = 4'($urandom_range(0, 5));
    d[5] = 4'($urandom_range(0, 9));
    if ($urandom_range(0, 9) == 0) d[$urandom_range(0, NUM_DIGITS - 1)] = BLANK_CODE;
    return d;
  endfunction

  // ---------------------------------------------------------------------
  // output side: random stalls, or a counted hold-off when one is asked
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (gaps_on) begin
      m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // every result beat against the oldest expectation, field by field
  always @(posedge clk) begin
    display_t want;
    bit bad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (expected_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected result beat %h at %0t", m_axis_tdata, $realtime);
      end else begin
        want = expected_displays.pop_front();
        bad  = (m_axis_tdata[31:27] != '0) || (m_axis_tdata[26:25] != want.mode) ||
               (m_axis_tdata[24] != want.hv);
        for (int i = 0; i < NUM_DIGITS; i++)
          if (m_axis_tdata[4*i +: 4] != want.digits[i]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("mismatch at %0t: expected mode %0d hv %0b digits %h, got %h",
                     $realtime, want.mode, want.hv, want.digits, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_displays.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // off mode at reset intervals: field extremes and the undefined func
  task automatic test_after_reset();
    send_item(FUNC_TICK, '0, 1'b0);
    send_item(FUNC_TICK, '1, 1'b0);
    send_item(FUNC_UNDEF, digits_t'(24'h5A_3C96), 1'b1);
  endtask

  // zero interval: one animation step per tick, ends in static mode
  task automatic test_fly_in();
    send_item(FUNC_FLY_IN, digits_t'(24'h95_9532), 1'b0);
    repeat (7) send_item(FUNC_TICK, digits_t'(24'h95_9532), 1'b0);
  endtask

  // units set directly, wrap to the dark code, forced extra roll,
  // targets of blank code
  task automatic test_roll_down();
    send_item(FUNC_TICK, '0, 1'b0);
    send_item(FUNC_TICK, '0, 1'b1);
    send_item(FUNC_TICK, '0, 1'b0);
    send_item(FUNC_TICK, '1, 1'b0);
    send_item(FUNC_TICK, '1, 1'b1);
    send_item(FUNC_TICK, digits_t'(24'h0F_1F2F), 1'b0);
  endtask

  task automatic test_fly_out();
    send_item(FUNC_FLY_OUT, digits_t'(24'h12_3456), 1'b0);
    repeat (7) send_item(FUNC_TICK, digits_t'(24'h78_9012), 1'b0);
  endtask

  // off mode never clears the roll timers: run them past a long interval,
  // then fly in and check the first static tick rolls at once
  task automatic test_long_wait();
    int k;
    set_config(16'd120, 16'd120, 16'd120, 1'b1, 1'b0);
    gaps_on = 1'b0;
    for (k = 0; k < 150; k++) send_item(FUNC_TICK, rand_clock_time(), 1'b0);
    gaps_on = 1'b1;
    set_config(16'h0000, 16'd120, 16'd120, 1'b1, 1'b0);
    send_item(FUNC_FLY_IN, digits_t'(24'h55_5555), 1'b0);
    repeat (7) send_item(FUNC_TICK, digits_t'(24'h55_5555), 1'b0);
    send_item(FUNC_TICK, digits_t'(24'h11_1111), 1'b1);
    send_item(FUNC_TICK, digits_t'(24'h11_1111), 1'b0);
  endtask

  // mostly ticks toward a steady target, with commands, force requests
  // and raw digit noise mixed in
  task automatic test_random(input int n_items, input int anim_max, input int roll_max);
    int k;
    int r;
    logic [1:0] fn;
    logic fr;
    digits_t goal;
    set_config(16'($urandom_range(0, anim_max)), 16'($urandom_range(0, roll_max)),
               16'($urandom_range(0, roll_max)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    goal = rand_clock_time();
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3)      fn = FUNC_FLY_IN;
      else if (r < 5) fn = FUNC_FLY_OUT;
      else if (r < 7) fn = FUNC_UNDEF;
      else            fn = FUNC_TICK;
      fr = ($urandom_range(0, 99) < 5);
      if ($urandom_range(0, 99) < 4) goal = rand_clock_time();
      if ($urandom_range(0, 99) < 6)
        send_item(fn, digits_t'($urandom_range(0, 32'hFF_FFFF)), fr);
      else
        send_item(fn, goal, fr);
    end
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    int k;
    set_config(16'd1, 16'd2, 16'd3, 1'b1, 1'b1);
    gaps_on   = 1'b0;
    hold_left = 150;
    send_item(FUNC_FLY_IN, rand_clock_time(), 1'b0);
    for (k = 0; k < 40; k++) send_item(FUNC_TICK, digits_t'(24'h20_4513), k[3]);
    gaps_on = 1'b1;
  endtask

  // sender stops mid-stream until the output has fully drained
  task automatic test_sender_pause();
    int k;
    for (k = 0; k < 10; k++) send_item(FUNC_TICK, digits_t'(24'h09_1807), 1'b0);
    wait_for_results();
    for (k = 0; k < 10; k++) send_item(FUNC_TICK, digits_t'(24'h18_0709), k == 2);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    set_config(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    test_fly_in();
    test_roll_down();
    test_fly_out();
    test_long_wait();

    test_random(160, 3, 3);
    test_random(160, 1, 0);
    gaps_on = 1'b0;
    test_random(160, 2, 6);
    gaps_on = 1'b1;
    test_random(160, 12, 30);
    test_backpressure();
    test_sender_pause();
    test_random(160, 4, 8);

    wait_for_results();
    repeat (4) @(posedge clk);
    if (expected_displays.size() != 0) begin
      $display("%0d expected results never arrived", expected_displays.size());
      mismatches++;
    end
    $display("sent %0d beats, checked %0d results over %0d register settings in %0d cycles",
             items_sent, results_checked, settings_used, cycle_count);
    $display("covered fly-in/out, rolls with force and both wraps, long waits, stalls");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatching beats", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
